>>> hdl/srgb8_to_oklab_pixel_core_macros.svh
// ---------------------------------------------------------------------------
// srgb8_to_oklab_pixel_core assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SRGB8_TO_OKLAB_PIXEL_CORE_MACROS_SVH
`define SRGB8_TO_OKLAB_PIXEL_CORE_MACROS_SVH

`ifndef SYNTH

`define S2OK_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2ok check failed");

`define S2OK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2ok check failed");

`else

`define S2OK_ASSERT_SAME(lbl, ante, cons)

`define S2OK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/s2ok_pkg.sv
// ---------------------------------------------------------------------------
// s2ok_pkg
// Constants, decode table and divider helpers for the sRGB to Oklab core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2ok_pkg;

  localparam int FRAC_LIN   = 20;
  localparam int LIN_W      = 21;
  localparam int LMS_W      = 21;
  localparam int ROOT_W     = 22;
  localparam int CUBE_STEPS = 22;
  localparam int SQ_W       = 24;
  localparam int CUBE_W     = 26;
  localparam int DNUM_W     = 48;
  localparam int DQ_W       = 25;
  localparam int LUMN_W     = 26;

  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [DNUM_W-1:0] dnum_t;
  typedef logic [DQ_W-1:0]   dq_t;
  typedef lin_t rom_t [256];

  localparam logic [32:0] LMS_COEF [3][3] = '{
    '{33'd4122214708, 33'd5363325363, 33'd514459929},
    '{33'd2119034982, 33'd6806995451, 33'd1073969566},
    '{33'd883024619,  33'd2817188376, 33'd6299787005}
  };

  localparam logic signed [35:0] LAB_COEF [3][3] = '{
    '{ 36'sd2104542553,   36'sd7936177850,  -36'sd40720468},
    '{ 36'sd19779984951, -36'sd24285922050,  36'sd4505937099},
    '{ 36'sd259040371,    36'sd7827717662,  -36'sd8086757660}
  };

  localparam logic [12:0] LUM_WGT [3] = '{13'd2126, 13'd7152, 13'd722};

  localparam logic [32:0] COEF_HALF = 33'd5000000000;
  localparam logic signed [59:0] LAB_BIAS = 60'sd83886080000000000;
  localparam logic [23:0] DIV_D = 24'd9765625;
  localparam logic [DQ_W-1:0] DIV_M = DQ_W'((64'd1 << 48) / 64'd9765625);
  localparam logic [16:0] LUM_OFS = 17'd80000;
  localparam logic [9:0]  LUM_D = 10'd625;
  localparam logic [26:0] LUM_M = 27'((64'd1 << 36) / 64'd625);

  function automatic logic [63:0] fifth_trunc(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = (y * y) >> 30;
    y4 = (y2 * y2) >> 30;
    return (y4 * y) >> 30;
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] cand;
    logic [63:0] v;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        v = (((64'(c) * 64'd100) << 20) + 64'd164730) / 64'd329460;
      end else begin
        x  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        x2 = (x * x) >> 30;
        y  = '0;
        for (int b = 30; b >= 0; b--) begin
          cand = y | (64'd1 << b);
          if (fifth_trunc(cand) <= x2) begin
            y = cand;
          end
        end
        v = (((x2 * y) >> 30) + 64'd512) >> 10;
      end
      t[c] = v[LIN_W-1:0];
    end
    return t;
  endfunction

  localparam rom_t DEC_ROM = build_rom();

  // quotient estimate by 1e10/1024, never high, at most two low
  function automatic logic [56:0] div_qm(input dnum_t n);
    return 57'(n[47:16]) * 57'(DIV_M);
  endfunction

  function automatic dnum_t div_pr(input dq_t q);
    logic [48:0] p;
    p = 49'(q) * 49'(DIV_D);
    return p[DNUM_W-1:0];
  endfunction

  function automatic dq_t div_fix(input dnum_t n, input dq_t q, input dnum_t pr);
    dnum_t r;
    r = n - pr;
    if (r >= DNUM_W'({DIV_D, 1'b0})) begin
      return q + DQ_W'(2);
    end else if (r >= DNUM_W'(DIV_D)) begin
      return q + DQ_W'(1);
    end
    return q;
  endfunction

  function automatic logic [15:0] sat_out(input dq_t q);
    logic [19:0]        t;
    logic signed [20:0] o;
    t = 20'((26'(q) + 26'd32) >> 6);
    o = $signed({1'b0, t}) - 21'sd131072;
    if (o > 21'sd32767) begin
      return 16'h7FFF;
    end else if (o < -21'sd32768) begin
      return 16'h8000;
    end
    return o[15:0];
  endfunction

endpackage

>>> hdl/srgb8_to_oklab_pixel_core.sv
// ---------------------------------------------------------------------------
// srgb8_to_oklab_pixel_core
// Streaming sRGB pixel to Oklab L, a, b and Rec.709 luminance converter.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel request per accepted beat, tdata = {blue, green, red}.
//   out_* : one result per pixel, tdata = {luma, b, a, L}, same order.
//   One pixel is taken every cycle while the output is not stalled. Depth is
//   set by the cube root, one result bit per two stages (square, then cube and
//   compare) for 22 bits, plus two constant-divider chains of three stages each
//   and the decode, product and sum registers.
//   The whole pipeline moves together: in_tready is high while the output
//   register is empty or being taken. When the receiver holds out_tready low
//   with a result waiting, every stage holds and in_tready drops; nothing is
//   lost or repeated.
//   Reset clears all valid bits; no result is presented until a request
//   has passed through. The decode table is constant logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "srgb8_to_oklab_pixel_core_macros.svh"

module srgb8_to_oklab_pixel_core
  import s2ok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // lightness, green_red_axis, blue_yellow_axis, luminance
);

  localparam int NST    = 54;
  localparam int LUMD_N = 48;

  logic           adv;
  logic [NST-1:0] v_r;
  logic           out_valid_r;

  // front: decode, LMS sums, division
  lin_t            lin_r   [3];
  logic [53:0]     plms_r  [3][3];
  logic [33:0]     plum_r  [3];
  dnum_t           nl3_r   [3];
  logic [LUMN_W-1:0] nu3_r;
  logic [56:0]     qml_r   [3];
  dnum_t           nl4_r   [3];
  logic [52:0]     qmu_r;
  logic [LUMN_W-1:0] nu4_r;
  dq_t             qel_r   [3];
  dnum_t           prl_r   [3];
  dnum_t           nl5_r   [3];
  logic [16:0]     qeu_r;
  logic [26:0]     pru_r;
  logic [LUMN_W-1:0] nu5_r;
  logic [LMS_W-1:0] lms_r  [3];
  logic [15:0]     lum_r;

  // cube root steps
  logic [ROOT_W-1:0] ca_r  [3][CUBE_STEPS];
  logic [ROOT_W-1:0] ra_r  [3][CUBE_STEPS];
  logic [SQ_W-1:0]   sqa_r [3][CUBE_STEPS];
  logic [LMS_W-1:0]  la_r  [3][CUBE_STEPS];
  logic [ROOT_W-1:0] rb_r  [3][CUBE_STEPS];
  logic [LMS_W-1:0]  lb_r  [3][CUBE_STEPS];
  logic [ROOT_W-1:0] ca_nxt  [3][CUBE_STEPS];
  logic [ROOT_W-1:0] ra_nxt  [3][CUBE_STEPS];
  logic [SQ_W-1:0]   sqa_nxt [3][CUBE_STEPS];
  logic [LMS_W-1:0]  la_nxt  [3][CUBE_STEPS];
  logic [ROOT_W-1:0] rb_nxt  [3][CUBE_STEPS];

  // back: Oklab matrix and division
  logic signed [58:0] pl_r [3][3];
  dnum_t           nb1_r [3];
  logic [56:0]     qmb_r [3];
  dnum_t           nb2_r [3];
  dq_t             qeb_r [3];
  dnum_t           prb_r [3];
  dnum_t           nb3_r [3];
  logic [15:0]     lumd_r [LUMD_N];
  logic [15:0]     lab_r  [3];
  logic [15:0]     lumo_r;

  logic [57:0]        sl_nxt [3];
  logic [33:0]        su_nxt;
  logic signed [59:0] sb_nxt [3];
  dq_t                ql_nxt [3];
  logic [16:0]        qu_nxt;
  logic [26:0]        ru_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lumo_r, lab_r[2], lab_r[1], lab_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[NST-2:0], in_tvalid};
      out_valid_r <= v_r[NST-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sl_nxt[i] = 58'(plms_r[i][0]) + 58'(plms_r[i][1]) + 58'(plms_r[i][2])
                + 58'(COEF_HALF);
      sb_nxt[i] = 60'(pl_r[i][0]) + 60'(pl_r[i][1]) + 60'(pl_r[i][2])
                + 60'($signed({1'b0, COEF_HALF})) + LAB_BIAS;
      ql_nxt[i] = div_fix(nl5_r[i], qel_r[i], prl_r[i]);
    end
    su_nxt = 34'(plum_r[0]) + 34'(plum_r[1]) + 34'(plum_r[2]) + 34'(LUM_OFS);
    ru_nxt = 27'(nu5_r) - pru_r;
    qu_nxt = (ru_nxt >= 27'(LUM_D)) ? qeu_r + 17'd1 : qeu_r;
  end

  always_comb begin
    logic [ROOT_W-1:0] src_r;
    logic [LMS_W-1:0]  src_l;
    logic [43:0]       p_sq;
    logic [45:0]       p_cu;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < CUBE_STEPS; k++) begin
        src_r = (k == 0) ? '0 : rb_r[c][(k == 0) ? 0 : k-1];
        src_l = (k == 0) ? lms_r[c] : lb_r[c][(k == 0) ? 0 : k-1];
        ca_nxt[c][k]  = src_r | (ROOT_W'(1) << (CUBE_STEPS-1-k));
        ra_nxt[c][k]  = src_r;
        la_nxt[c][k]  = src_l;
        p_sq          = 44'(ca_nxt[c][k]) * 44'(ca_nxt[c][k]);
        sqa_nxt[c][k] = p_sq[43:FRAC_LIN];
        p_cu          = 46'(sqa_r[c][k]) * 46'(ca_r[c][k]);
        rb_nxt[c][k]  = (p_cu[45:FRAC_LIN] <= CUBE_W'(la_r[c][k])) ? ca_r[c][k]
                                                                  : ra_r[c][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r[0] <= DEC_ROM[in_tdata[7:0]];
      lin_r[1] <= DEC_ROM[in_tdata[15:8]];
      lin_r[2] <= DEC_ROM[in_tdata[23:16]];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          plms_r[i][j] <= 54'(LMS_COEF[i][j]) * 54'(lin_r[j]);
          pl_r[i][j]   <= 59'(LAB_COEF[i][j]) * 59'($signed({1'b0, rb_r[j][CUBE_STEPS-1]}));
        end
        plum_r[i] <= 34'(LUM_WGT[i]) * 34'(lin_r[i]);
        nl3_r[i]  <= sl_nxt[i][57:10];
        qml_r[i]  <= div_qm(nl3_r[i]);
        nl4_r[i]  <= nl3_r[i];
        qel_r[i]  <= qml_r[i][56:32];
        prl_r[i]  <= div_pr(qml_r[i][56:32]);
        nl5_r[i]  <= nl4_r[i];
        lms_r[i]  <= (ql_nxt[i] > DQ_W'({LMS_W{1'b1}})) ? {LMS_W{1'b1}}
                                                        : ql_nxt[i][LMS_W-1:0];
        nb1_r[i]  <= sb_nxt[i][57:10];
        qmb_r[i]  <= div_qm(nb1_r[i]);
        nb2_r[i]  <= nb1_r[i];
        qeb_r[i]  <= qmb_r[i][56:32];
        prb_r[i]  <= div_pr(qmb_r[i][56:32]);
        nb3_r[i]  <= nb2_r[i];
        lab_r[i]  <= sat_out(div_fix(nb3_r[i], qeb_r[i], prb_r[i]));
      end
      nu3_r <= su_nxt[33:8];
      qmu_r <= 53'(nu3_r) * 53'(LUM_M);
      nu4_r <= nu3_r;
      qeu_r <= qmu_r[52:36];
      pru_r <= 27'(qmu_r[52:36]) * 27'(LUM_D);
      nu5_r <= nu4_r;
      lum_r <= (qu_nxt > 17'd65535) ? 16'hFFFF : qu_nxt[15:0];
      lumd_r[0] <= lum_r;
      for (int d = 1; d < LUMD_N; d++) begin
        lumd_r[d] <= lumd_r[d-1];
      end
      lumo_r <= lumd_r[LUMD_N-1];
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < CUBE_STEPS; k++) begin
          ca_r[c][k]  <= ca_nxt[c][k];
          ra_r[c][k]  <= ra_nxt[c][k];
          sqa_r[c][k] <= sqa_nxt[c][k];
          la_r[c][k]  <= la_nxt[c][k];
          rb_r[c][k]  <= rb_nxt[c][k];
          lb_r[c][k]  <= la_r[c][k];
        end
      end
    end
  end

  `S2OK_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, v_r[0])
  `S2OK_ASSERT_NEXT(a_stall_holds_out, out_tvalid && !out_tready, out_tvalid)
  `S2OK_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(v_r))
  `S2OK_ASSERT_NEXT(a_last_stage_out, adv && v_r[NST-1], out_tvalid)

endmodule

>>> dv/tb_srgb8_to_oklab_pixel_core.sv
// ---------------------------------------------------------------------------
// tb_srgb8_to_oklab_pixel_core
// Streams sRGB pixels through the converter under varied idle and stall
// patterns. Each result is checked field by field against an exact fixed
// point predictor of the decode, LMS, cube root, Oklab and luminance paths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_srgb8_to_oklab_pixel_core;

  localparam int  LIN_FRAC   = 20;
  localparam int  LAB_FRAC   = 14;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  DRAIN_WAIT = 80;
  localparam longint SCALE   = 64'sd10000000000;
  localparam longint HALF    = 64'sd5000000000;

  typedef struct packed {
    logic [15:0] luminance;
    logic [15:0] blue_yellow_axis;
    logic [15:0] green_red_axis;
    logic [15:0] lightness;
  } oklab_px_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red_in, green_in, blue_in
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // lightness, green_red_axis, blue_yellow_axis, luminance

  srgb8_to_oklab_pixel_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  longint    lin_table [256];
  oklab_px_t oklab_due [$];
  int        mismatches;
  int        idle_pct;
  int        stall_pct;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint div_floor(longint x, longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic longint pow5_trunc(longint y);
    longint y2;
    longint y4;
    y2 = (y * y) >>> 30;
    y4 = (y2 * y2) >>> 30;
    return (y4 * y) >>> 30;
  endfunction

  task automatic fill_lin_table();
    longint x;
    longint x2;
    longint y;
    longint cand;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        lin_table[c] = ((longint'(c) * 100 << LIN_FRAC) + 164730) / 329460;
      end else begin
        x  = ((longint'(c) * 1000 + 14025) << 30) / 269025;
        x2 = (x * x) >>> 30;
        y  = 0;
        for (int b = 30; b >= 0; b--) begin
          cand = y | (64'sd1 << b);
          if (pow5_trunc(cand) <= x2) y = cand;
        end
        lin_table[c] = (((x2 * y) >>> 30) + (64'sd1 << (29 - LIN_FRAC))) >>> (30 - LIN_FRAC);
      end
    end
  endtask

  function automatic longint cbrt_q(longint v);
    longint r;
    longint cand;
    longint t;
    r = 0;
    for (int b = LIN_FRAC + 1; b >= 0; b--) begin
      cand = r | (64'sd1 << b);
      t    = (cand * cand) >>> LIN_FRAC;
      if (((t * cand) >>> LIN_FRAC) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [15:0] lab_q14(longint v);
    longint o;
    o = div_floor(v + (64'sd1 << (LIN_FRAC - LAB_FRAC - 1)), 64'sd1 << (LIN_FRAC - LAB_FRAC));
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  function automatic oklab_px_t predict_oklab(logic [23:0] px);
    longint lms_coef [3][3] = '{
      '{64'sd4122214708, 64'sd5363325363, 64'sd514459929},
      '{64'sd2119034982, 64'sd6806995451, 64'sd1073969566},
      '{64'sd883024619,  64'sd2817188376, 64'sd6299787005}};
    longint lab_coef [3][3] = '{
      '{64'sd2104542553,  64'sd7936177850,  -64'sd40720468},
      '{64'sd19779984951, -64'sd24285922050, 64'sd4505937099},
      '{64'sd259040371,   64'sd7827717662,  -64'sd8086757660}};
    longint    wgt [3] = '{2126, 7152, 722};
    longint    lin [3];
    longint    root [3];
    longint    s;
    longint    ysum;
    longint    den;
    longint    yq;
    oklab_px_t r;
    for (int i = 0; i < 3; i++) lin[i] = lin_table[px[8*i +: 8]];
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += lms_coef[i][j] * lin[j];
      s = div_floor(s + HALF, SCALE);
      if (s < 0) s = 0;
      if (s > (64'sd2 << LIN_FRAC) - 1) s = (64'sd2 << LIN_FRAC) - 1;
      root[i] = cbrt_q(s);
    end
    s = 0;
    for (int j = 0; j < 3; j++) s += lab_coef[0][j] * root[j];
    r.lightness = lab_q14(div_floor(s + HALF, SCALE));
    s = 0;
    for (int j = 0; j < 3; j++) s += lab_coef[1][j] * root[j];
    r.green_red_axis = lab_q14(div_floor(s + HALF, SCALE));
    s = 0;
    for (int j = 0; j < 3; j++) s += lab_coef[2][j] * root[j];
    r.blue_yellow_axis = lab_q14(div_floor(s + HALF, SCALE));
    ysum = 0;
    for (int j = 0; j < 3; j++) ysum += wgt[j] * lin[j];
    den = 64'sd10000 << LIN_FRAC;
    yq  = ((ysum << 16) + den / 2) / den;
    if (yq > 65535) yq = 65535;
    r.luminance = yq[15:0];
    return r;
  endfunction

  // scoreboard: predict at request acceptance, compare at result acceptance
  always @(posedge clk) begin
    oklab_px_t exp_px;
    oklab_px_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) oklab_due.push_back(predict_oklab(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (oklab_due.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          mismatches++;
        end else begin
          exp_px = oklab_due.pop_front();
          if (got.lightness !== exp_px.lightness) begin
            $error("lightness exp %0d got %0d",
                   $signed(exp_px.lightness), $signed(got.lightness));
            mismatches++;
          end
          if (got.green_red_axis !== exp_px.green_red_axis) begin
            $error("green_red_axis exp %0d got %0d",
                   $signed(exp_px.green_red_axis), $signed(got.green_red_axis));
            mismatches++;
          end
          if (got.blue_yellow_axis !== exp_px.blue_yellow_axis) begin
            $error("blue_yellow_axis exp %0d got %0d",
                   $signed(exp_px.blue_yellow_axis), $signed(got.blue_yellow_axis));
            mismatches++;
          end
          if (got.luminance !== exp_px.luminance) begin
            $error("luminance exp %0d got %0d", exp_px.luminance, got.luminance);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = 24'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {blue, green, red};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (oklab_due.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] codes [8] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255, 8'd170};
    idle_pct  = 0;
    stall_pct = 0;
    foreach (codes[k]) send_pixel(codes[k], codes[k], codes[k]);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd10, 8'd11, 8'd0);
    send_pixel(8'd85, 8'd170, 8'd85);
    for (int b = 0; b < 8; b++) send_pixel(8'd1 << b, 8'd1 << b, ~(8'd1 << b));
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_pixel(8'($urandom_range(10)), 8'($urandom_range(10)), 8'($urandom_range(10)));
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_pause_until_drained();
    idle_pct  = 0;
    stall_pct = 30;
    test_random(20, 0, 30);
    wait_drained();
    test_random(20, 0, 30);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    mismatches = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    quiet_cycles = 0;
    fill_lin_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(500, 0, 0);
    test_random(450, 70, 0);
    test_random(450, 0, 70);
    test_random(450, 29, 29);
    test_pause_until_drained();
    test_random(60, 0, 0);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && oklab_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> srgb8_to_oklab_pixel_core.f
+incdir+hdl
hdl/s2ok_pkg.sv
hdl/srgb8_to_oklab_pixel_core.sv
dv/tb_srgb8_to_oklab_pixel_core.sv
